// ===== hdl/bank_switch_scanline_irq_mapper_assert.svh =====
// assertion macros used by the mapper controller
`ifndef BANK_SWITCH_SCANLINE_IRQ_MAPPER_ASSERT_SVH
`define BANK_SWITCH_SCANLINE_IRQ_MAPPER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BSSIM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mapper check failed");

// next-cycle implication, sampled on clock, off during reset
`define BSSIM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mapper check failed");

`endif

// ===== hdl/bssim_pkg.sv =====
// types and constants of the bank switch scanline irq mapper
package bssim_pkg;

   localparam int unsigned CHR_SLOTS = 8;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_CPU   = 2'd2;
   localparam logic [1:0] MODE_PPU   = 2'd3;

   localparam logic [1:0] CSR_PRG_PAGES = 2'd0;
   localparam logic [1:0] CSR_CHR_PAGES = 2'd1;

   localparam logic [15:0] PRG_SEL_LO  = 16'h8000;
   localparam logic [15:0] PRG_SEL_HI  = 16'h8002;
   localparam logic [15:0] CHR_SEL_LO  = 16'hA000;
   localparam logic [15:0] CHR_SEL_HI  = 16'hA007;
   localparam logic [15:0] IRQ_LINE_LO = 16'hC001;
   localparam logic [15:0] IRQ_LINE_HI = 16'hC003;
   localparam logic [15:0] IRQ_ENABLE  = 16'hE000;
   localparam logic [15:0] CPU_ROM_LO  = 16'h8000;
   localparam logic [15:0] PPU_TOP     = 16'h2000;

   localparam logic [8:0]  PRG_PAGES_RESET = 9'd16;
   localparam logic [10:0] CHR_PAGES_RESET = 11'd8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [8:0]  scanline;
   } req_type;

   typedef struct packed {
      logic       irq_request;
      logic [8:0] page;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_last;
   } dp_status_type;

endpackage

// ===== hdl/bssim_datapath.sv =====
// mapper datapath: config, bank slots, irq state, remainder unit, result register
module bssim_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [10:0]            csr_write_data,
   input  bssim_pkg::req_type     req_payload,
   input  bssim_pkg::dp_cmd_type  cmd,
   output bssim_pkg::dp_status_type status,
   output bssim_pkg::rsp_type     rsp_payload
);

   logic [8:0]  prg_pages_ff;
   logic [10:0] chr_pages_ff;
   logic [7:0]  prg_low_ff [2];
   logic [7:0]  prg_third_ff;
   logic        prg_third_written_ff;
   logic [7:0]  chr_slots_ff [bssim_pkg::CHR_SLOTS];
   logic [7:0]  compare_line_ff;
   logic        irq_armed_ff;
   logic        irq_allowed_ff;

   bssim_pkg::req_type item_ff;
   bssim_pkg::rsp_type rsp_ff;
   bssim_pkg::rsp_type rsp_in;
   logic [7:0]  rem_ff;
   logic [7:0]  rem_in;
   logic [7:0]  dividend_ff;
   logic [2:0]  step_ff;

   logic        is_write;
   logic        hit_prg;
   logic        hit_chr;
   logic        hit_line;
   logic        hit_enable;
   logic [10:0] divisor;
   logic [8:0]  shifted;
   logic [10:0] diff;
   logic [8:0]  last_page;
   logic [8:0]  second_last_page;
   logic        irq_hit;

   // address decode of the held item
   always_comb begin
      is_write   = (item_ff.mode == bssim_pkg::MODE_WRITE);
      hit_prg    = (item_ff.address >= bssim_pkg::PRG_SEL_LO)
                   && (item_ff.address <= bssim_pkg::PRG_SEL_HI);
      hit_chr    = (item_ff.address >= bssim_pkg::CHR_SEL_LO)
                   && (item_ff.address <= bssim_pkg::CHR_SEL_HI);
      hit_line   = (item_ff.address >= bssim_pkg::IRQ_LINE_LO)
                   && (item_ff.address <= bssim_pkg::IRQ_LINE_HI);
      hit_enable = (item_ff.address == bssim_pkg::IRQ_ENABLE);
      divisor    = hit_prg ? {2'b00, prg_pages_ff} : chr_pages_ff;
      status.needs_div = is_write
                         && ((hit_prg && (prg_pages_ff != 9'd0))
                             || (hit_chr && (chr_pages_ff != 11'd0)));
      status.div_last  = (step_ff == 3'd7);
   end

   // restoring remainder, one dividend bit per step
   always_comb begin
      shifted = {rem_ff, dividend_ff[7]};
      diff    = {2'b00, shifted} - divisor;
      rem_in  = ({2'b00, shifted} >= divisor) ? diff[7:0] : shifted[7:0];
   end

   always_comb begin
      last_page        = (prg_pages_ff != 9'd0) ? (prg_pages_ff - 9'd1) : 9'd0;
      second_last_page = (prg_pages_ff > 9'd1) ? (prg_pages_ff - 9'd2) : 9'd0;
      irq_hit = (item_ff.mode == bssim_pkg::MODE_TICK) && irq_armed_ff
                && irq_allowed_ff && ({1'b0, compare_line_ff} == item_ff.scanline);
      rsp_in.irq_request = irq_hit;
      rsp_in.page        = 9'd0;
      case (item_ff.mode)
         bssim_pkg::MODE_CPU: begin
            if (item_ff.address >= bssim_pkg::CPU_ROM_LO) begin
               case (item_ff.address[14:13]) inside
                  2'd0, 2'd1: rsp_in.page = {1'b0, prg_low_ff[item_ff.address[13]]};
                  2'd2: rsp_in.page = prg_third_written_ff ? {1'b0, prg_third_ff}
                                                           : second_last_page;
                  default: rsp_in.page = last_page;
               endcase
            end
         end
         bssim_pkg::MODE_PPU: begin
            if (item_ff.address < bssim_pkg::PPU_TOP) begin
               rsp_in.page = {1'b0, chr_slots_ff[item_ff.address[12:10]]};
            end
         end
         default: rsp_in.page = 9'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_pages_ff <= bssim_pkg::PRG_PAGES_RESET;
         chr_pages_ff <= bssim_pkg::CHR_PAGES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bssim_pkg::CSR_PRG_PAGES: prg_pages_ff <= csr_write_data[8:0];
            bssim_pkg::CSR_CHR_PAGES: chr_pages_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // mapper state, updated when an item commits
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_low_ff[0]        <= 8'd0;
         prg_low_ff[1]        <= 8'd1;
         prg_third_ff         <= 8'd0;
         prg_third_written_ff <= 1'b0;
         for (int i = 0; i < bssim_pkg::CHR_SLOTS; i++) begin
            chr_slots_ff[i] <= 8'(i);
         end
         compare_line_ff <= 8'd0;
         irq_armed_ff    <= 1'b0;
         irq_allowed_ff  <= 1'b1;
      end else if (cmd.commit) begin
         if (status.needs_div) begin
            if (hit_prg) begin
               if (item_ff.address[1]) begin
                  prg_third_ff         <= rem_ff;
                  prg_third_written_ff <= 1'b1;
               end else begin
                  prg_low_ff[item_ff.address[0]] <= rem_ff;
               end
            end else begin
               chr_slots_ff[item_ff.address[2:0]] <= rem_ff;
            end
         end
         if (is_write && hit_line) begin
            compare_line_ff <= item_ff.write_data;
            irq_armed_ff    <= (item_ff.write_data != 8'd0);
         end
         if (is_write && hit_enable) begin
            irq_allowed_ff <= item_ff.write_data[0];
         end
         if (irq_hit) begin
            irq_armed_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff     <= req_payload;
         dividend_ff <= req_payload.write_data;
         rem_ff      <= 8'd0;
         step_ff     <= 3'd0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[6:0], 1'b0};
         rem_ff      <= rem_in;
         step_ff     <= step_ff + 3'd1;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/bssim_ctrl.sv =====
// mapper controller: item sequencing and result handshake
`include "bank_switch_scanline_irq_mapper_assert.svh"

module bssim_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bssim_pkg::dp_status_type status,
   output bssim_pkg::dp_cmd_type   cmd
);

   bssim_pkg::state_type state_ff;
   bssim_pkg::state_type state_in;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bssim_pkg::ST_IDLE: begin
            if (req_valid) state_in = bssim_pkg::ST_EXEC;
         end
         bssim_pkg::ST_EXEC: begin
            if (status.needs_div) state_in = bssim_pkg::ST_DIVIDE;
            else if (out_free) state_in = bssim_pkg::ST_IDLE;
         end
         bssim_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = bssim_pkg::ST_COMMIT;
         end
         bssim_pkg::ST_COMMIT: begin
            if (out_free) state_in = bssim_pkg::ST_IDLE;
         end
         default: state_in = bssim_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         bssim_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         bssim_pkg::ST_EXEC:   cmd.commit   = !status.needs_div && out_free;
         bssim_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         bssim_pkg::ST_COMMIT: cmd.commit   = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bssim_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BSSIM_ASSERT_NEXT(a_accept_to_exec, req_valid && req_ready, state_ff == bssim_pkg::ST_EXEC)
   `BSSIM_ASSERT_NOW(a_commit_needs_room, cmd.commit, out_free)
   `BSSIM_ASSERT_NEXT(a_div_ends_in_commit, cmd.div_step && status.div_last, state_ff == bssim_pkg::ST_COMMIT)
   `BSSIM_ASSERT_NEXT(a_commit_shows_beat, cmd.commit, rsp_valid_ff)

endmodule

// ===== hdl/bank_switch_scanline_irq_mapper.sv =====
// top level of the bank switch scanline irq mapper
//
//   channel | ports                                  | direction
//   req     | req_valid, req_ready, req_payload      | in
//   rsp     | rsp_valid, rsp_ready, rsp_payload      | out
//   csr     | csr_write_enable, csr_index, csr_write_data | in, write only
//
// a beat is taken in idle; ticks, translations and writes that need no
// remainder commit from exec once the output register is free
// slot writes with a nonzero page count run the remainder unit, one dividend
// bit per cycle, and commit after it; a new beat waits for the commit
// synchronous reset restores page counts 16 and 8 and the power-on bank layout
// a stalled result sits in the output register while the next beat is taken
module bank_switch_scanline_irq_mapper (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  bssim_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bssim_pkg::rsp_type rsp_payload
);

   bssim_pkg::dp_cmd_type    cmd;
   bssim_pkg::dp_status_type status;

   bssim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bssim_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .status           (status),
      .rsp_payload      (rsp_payload)
   );

endmodule
